// ===== hdl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the trajectory smoother
// Widths, defaults, channel payloads and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DefaultRadius    = 50;
  localparam int DefaultRingDepth = 128;
  localparam int DeltaW           = 20;
  localparam int TrajW            = 32;
  localparam int SumW             = 40;
  localparam int IndexW           = 16;
  localparam int CountW           = 8;
  localparam int DivNumW          = 48;

  typedef struct packed {
    logic signed [DeltaW-1:0] delta_x;
    logic signed [DeltaW-1:0] delta_y;
    logic signed [DeltaW-1:0] delta_angle;
    logic                     last_frame;
  } frame_req_t;

  typedef struct packed {
    logic [IndexW-1:0]       frame_index;
    logic signed [TrajW-1:0] corrected_x;
    logic signed [TrajW-1:0] corrected_y;
    logic signed [TrajW-1:0] corrected_angle;
    logic                    end_of_run;
  } corrected_res_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INGEST,
    CMD_CLEAR_SUM,
    CMD_ACCUM,
    CMD_DIV_START,
    CMD_RESTART
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    advance;
    logic    grab_prev;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_status_t;

endpackage

// ===== hdl/mts_stream_if.sv =====
// ----------------------------------------------------------------------------
// mts_stream_if: valid/ready channel carrying one payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface mts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/mts_datapath.sv =====
// ----------------------------------------------------------------------------
// mts_datapath: trajectory store, window sums and rounding divider
// Holds the running trajectory, the ring memory and a serial divider with one lane per axis.
// ----------------------------------------------------------------------------
module mts_datapath #(
  parameter int RingDepth = mts_pkg::DefaultRingDepth
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mts_pkg::dp_cmd_t                    cmd,
  input  logic signed [mts_pkg::DeltaW-1:0]   delta_x,
  input  logic signed [mts_pkg::DeltaW-1:0]   delta_y,
  input  logic signed [mts_pkg::DeltaW-1:0]   delta_angle,
  input  logic        [mts_pkg::CountW-1:0]   count,
  output mts_pkg::dp_status_t                 status,
  output logic signed [mts_pkg::TrajW-1:0]    quot_x,
  output logic signed [mts_pkg::TrajW-1:0]    quot_y,
  output logic signed [mts_pkg::TrajW-1:0]    quot_angle
);
  localparam int SlotW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int TW = mts_pkg::TrajW;
  localparam int SW = mts_pkg::SumW;
  localparam int NW = mts_pkg::DivNumW;
  localparam int CW = mts_pkg::CountW;

  logic [3*TW-1:0]   ring [RingDepth];
  logic [SlotW-1:0]  wr_slot;
  logic [SlotW-1:0]  rd_ptr;
  logic signed [TW-1:0] run_x, run_y, run_a;
  logic [3*TW-1:0]   rd_data;
  logic signed [SW-1:0] sum_x, sum_y, sum_a;
  logic signed [TW-1:0] prev_x, prev_y, prev_a;
  logic              rd_pending;
  logic              rd_grab;

  // divider state
  logic [NW-1:0]     rem [3];
  logic [NW-1:0]     quo [3];
  logic              neg [3];
  logic [5:0]        div_cnt;
  logic              div_busy;
  logic [CW-1:0]     den;

  function automatic logic signed [TW-1:0] sat_add(logic signed [TW-1:0] a,
                                                  logic signed [mts_pkg::DeltaW-1:0] b);
    logic signed [TW:0] s;
    s = {a[TW-1], a} + (TW+1)'(b);
    if (s[TW] != s[TW-1]) begin
      return s[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end
    return s[TW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] sat_q(logic [NW-1:0] q, logic n);
    logic signed [NW:0] v;
    v = n ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > (NW+1)'(64'sh7FFFFFFF)) return {1'b0, {(TW-1){1'b1}}};
    if (v < -(NW+1)'(64'sh80000000)) return {1'b1, {(TW-1){1'b0}}};
    return v[TW-1:0];
  endfunction

  logic signed [TW-1:0] nx, ny, na;
  assign nx = sat_add(run_x, delta_x);
  assign ny = sat_add(run_y, delta_y);
  assign na = sat_add(run_a, delta_angle);

  always_ff @(posedge clk) begin
    if (cmd.op == mts_pkg::CMD_INGEST) begin
      ring[wr_slot] <= {nx, ny, na};
    end
    rd_data <= ring[rd_ptr];
  end

  // numerator = sum - count*prev, 40 bits sum + 41 bit product fits in 48
  logic signed [NW-1:0] num [3];
  logic signed [NW-1:0] prod [3];
  always_comb begin
    prod[0] = NW'(prev_x) * $signed({1'b0, count});
    prod[1] = NW'(prev_y) * $signed({1'b0, count});
    prod[2] = NW'(prev_a) * $signed({1'b0, count});
    num[0] = NW'(sum_x) - prod[0];
    num[1] = NW'(sum_y) - prod[1];
    num[2] = NW'(sum_a) - prod[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot <= '0;
      rd_ptr <= '0;
      run_x <= '0; run_y <= '0; run_a <= '0;
      rd_pending <= 1'b0;
      div_busy <= 1'b0;
      div_cnt <= '0;
    end else begin
      rd_pending <= cmd.op == mts_pkg::CMD_ACCUM;
      rd_grab <= (cmd.op == mts_pkg::CMD_ACCUM) && cmd.grab_prev;
      unique case (cmd.op)
        mts_pkg::CMD_INGEST: begin
          run_x <= nx; run_y <= ny; run_a <= na;
        end
        mts_pkg::CMD_RESTART: begin
          run_x <= '0; run_y <= '0; run_a <= '0;
          wr_slot <= '0;
        end
        mts_pkg::CMD_CLEAR_SUM: begin
          // advance to the next frame's slot, or start a walk at the newest frame
          if (cmd.advance) begin
            wr_slot <= (32'(wr_slot) == RingDepth - 1) ? '0 : wr_slot + 1'b1;
          end
          rd_ptr <= wr_slot;
          sum_x <= '0; sum_y <= '0; sum_a <= '0;
          prev_x <= '0; prev_y <= '0; prev_a <= '0;
        end
        mts_pkg::CMD_ACCUM: begin
          // step one frame back, wrapping around the ring
          rd_ptr <= (rd_ptr == '0) ? SlotW'(RingDepth - 1) : rd_ptr - 1'b1;
        end
        mts_pkg::CMD_DIV_START: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= num[i][NW-1];
            rem[i] <= '0;
            quo[i] <= (num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]))
                      + NW'(count >> 1);
          end
          den <= count;
          div_cnt <= '0;
          div_busy <= 1'b1;
        end
        default: ;
      endcase
      if (rd_pending) begin
        sum_x <= sum_x + SW'($signed(rd_data[3*TW-1:2*TW]));
        sum_y <= sum_y + SW'($signed(rd_data[2*TW-1:TW]));
        sum_a <= sum_a + SW'($signed(rd_data[TW-1:0]));
        if (rd_grab) begin
          prev_x <= rd_data[3*TW-1:2*TW];
          prev_y <= rd_data[2*TW-1:TW];
          prev_a <= rd_data[TW-1:0];
        end
      end
      if (div_busy) begin
        for (int i = 0; i < 3; i++) begin
          logic [NW:0] trial;
          trial = {rem[i], quo[i][NW-1]} - {1'b0, (NW)'(den)};
          if (!trial[NW]) begin
            rem[i] <= trial[NW-1:0];
            quo[i] <= {quo[i][NW-2:0], 1'b1};
          end else begin
            rem[i] <= {rem[i][NW-2:0], quo[i][NW-1]};
            quo[i] <= {quo[i][NW-2:0], 1'b0};
          end
        end
        div_cnt <= div_cnt + 1'b1;
        if (32'(div_cnt) == NW - 1) div_busy <= 1'b0;
      end
    end
  end

  assign status.div_busy = div_busy;
  assign quot_x = sat_q(quo[0], neg[0]);
  assign quot_y = sat_q(quo[1], neg[1]);
  assign quot_angle = sat_q(quo[2], neg[2]);
endmodule

// ===== hdl/mts_controller.sv =====
// ----------------------------------------------------------------------------
// mts_controller: sequencer of the trajectory smoother
// Accept a frame, walk the window through the ring, divide, present a result.
// ----------------------------------------------------------------------------
module mts_controller #(
  parameter int Radius = mts_pkg::DefaultRadius
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mts_pkg::IndexW-1:0]        frame_index,
  output logic                              end_of_run,
  output logic [mts_pkg::CountW-1:0]        count,
  output mts_pkg::dp_cmd_t                  cmd,
  input  mts_pkg::dp_status_t               status
);
  localparam int CW = mts_pkg::CountW;
  localparam int IW = mts_pkg::IndexW;
  localparam logic [CW-1:0] RadiusC = CW'(Radius);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SUM, S_TAIL, S_DRAIN, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t          state;
  logic [IW-1:0]   frames;       // frames of this sequence before current one
  logic            ovf;
  logic            last;
  logic [CW-1:0]   b, hi, walk;
  logic [1:0]      drain;
  logic [IW-1:0]   n_minus1;

  assign in_ready = state == S_IDLE;
  assign n_minus1 = frames;

  always_ff @(posedge clk) begin
    mts_pkg::dp_cmd_t cmd_next;
    cmd_next = '{op: mts_pkg::CMD_NONE, advance: 1'b0, grab_prev: 1'b0};
    if (rst) begin
      state <= S_IDLE;
      frames <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_next.op = mts_pkg::CMD_INGEST;
            last <= in_last;
            ovf <= &frames;
            b <= (frames > IW'(Radius)) ? RadiusC : CW'(frames);
            state <= S_START;
          end
        end
        S_START: begin
          if (!last && frames < IW'(Radius)) begin
            cmd_next = '{op: mts_pkg::CMD_CLEAR_SUM, advance: 1'b1, grab_prev: 1'b0};
            frames <= frames + 1'b1;
            state <= S_IDLE;
          end else begin
            // window spans newest back to b+Radius, clipped to frame 0
            hi <= (32'(b) + Radius > 32'(frames)) ? CW'(frames) : b + RadiusC;
            cmd_next = '{op: mts_pkg::CMD_CLEAR_SUM, advance: 1'b0, grab_prev: 1'b0};
            walk <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // the previous raw point lies one frame behind b; catch it on the way
          cmd_next = '{op: mts_pkg::CMD_ACCUM, advance: 1'b0,
                       grab_prev: (walk == b + 1'b1) && (IW'(b) != frames)};
          count <= hi + 1'b1;
          if (walk == hi) begin
            state <= S_TAIL;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_TAIL: begin
          drain <= '0;
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == 2'd2) begin
            cmd_next.op = mts_pkg::CMD_DIV_START;
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (!status.div_busy) begin
            out_valid <= 1'b1;
            frame_index <= ovf ? '1 : n_minus1 - IW'(b);
            end_of_run <= last && b == '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last && b != '0) begin
              b <= b - 1'b1;
              hi <= (32'(b) - 1 + Radius > 32'(frames)) ? CW'(frames)
                    : b - 1'b1 + RadiusC;
              cmd_next = '{op: mts_pkg::CMD_CLEAR_SUM, advance: 1'b0, grab_prev: 1'b0};
              walk <= '0;
              state <= S_SUM;
            end else if (last) begin
              cmd_next.op = mts_pkg::CMD_RESTART;
              frames <= '0;
              state <= S_IDLE;
            end else begin
              cmd_next = '{op: mts_pkg::CMD_CLEAR_SUM, advance: 1'b1, grab_prev: 1'b0};
              if (!ovf) frames <= frames + 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    cmd <= cmd_next;
  end
endmodule

// ===== hdl/motion_trajectory_smoother.sv =====
// ----------------------------------------------------------------------------
// motion_trajectory_smoother: moving-average trajectory smoothing
// Accumulates per-frame motion, smooths with a centered window, emits
// the corrected motion per frame.
// ----------------------------------------------------------------------------
// One request at a time. Each result walks its window through the ring
// memory one entry per cycle (up to 2*Radius+1 reads, 101 at the default
// radius) and picks up the previous trajectory point during that walk, then
// runs a 48-step serial rounding divider. After a frame that completes a
// window, the next request is accepted only once the receiver has taken the
// result; a frame that completes no window yields no result. The last frame
// flushes min(n, Radius+1) results, oldest first, and then restarts the
// sequence at frame 0.
module motion_trajectory_smoother #(
  parameter int WindowRadius = mts_pkg::DefaultRadius,
  parameter int RingDepth    = mts_pkg::DefaultRingDepth
) (
  input  logic         clk,
  input  logic         rst,
  mts_stream_if.sink   in_req,
  mts_stream_if.source out_res
);
  mts_pkg::dp_cmd_t    cmd;
  mts_pkg::dp_status_t status;
  logic [mts_pkg::CountW-1:0] count;
  logic [mts_pkg::IndexW-1:0] frame_index;
  logic end_of_run;
  logic signed [mts_pkg::TrajW-1:0] qx, qy, qa;
  logic signed [mts_pkg::DeltaW-1:0] req_dx, req_dy, req_da;

  // hold the accepted motion until the datapath ingests it in the next cycle
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_dx <= in_req.payload.delta_x;
      req_dy <= in_req.payload.delta_y;
      req_da <= in_req.payload.delta_angle;
    end
  end

  // sequence the request through ingest, window sum and divide
  mts_controller #(.Radius(WindowRadius)) u_ctrl (
    .clk, .rst,
    .in_valid(in_req.valid), .in_ready(in_req.ready),
    .in_last(in_req.payload.last_frame),
    .out_valid(out_res.valid), .out_ready(out_res.ready),
    .frame_index, .end_of_run, .count, .cmd, .status
  );

  // hold trajectory, ring and divider
  mts_datapath #(.RingDepth(RingDepth)) u_dp (
    .clk, .rst, .cmd,
    .delta_x(req_dx), .delta_y(req_dy), .delta_angle(req_da),
    .count, .status, .quot_x(qx), .quot_y(qy), .quot_angle(qa)
  );

  assign out_res.payload.frame_index = frame_index;
  assign out_res.payload.corrected_x = qx;
  assign out_res.payload.corrected_y = qy;
  assign out_res.payload.corrected_angle = qa;
  assign out_res.payload.end_of_run = end_of_run;

`ifndef ASSERT_OFF
  // never take a request while a result is still offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_res.valid |-> !in_req.ready) else $error("request taken during output");
  // divider never runs while a result is shown
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    out_res.valid |-> !status.div_busy) else $error("divider busy at output");
`endif
endmodule

// ===== tb/sv/motion_trajectory_smoother_tb.sv =====
// ----------------------------------------------------------------------------
// motion_trajectory_smoother_tb: self-checking bench of the trajectory smoother
// Drives motion requests over the input channel and predicts each corrected
// motion from a software copy of the ring and trajectory sums. Every result is
// compared field by field against the oldest prediction; random stalls and
// gaps cover both sides of the handshake.
// ----------------------------------------------------------------------------
module motion_trajectory_smoother_tb;

  localparam int Radius     = mts_pkg::DefaultRadius;
  localparam int Depth      = mts_pkg::DefaultRingDepth;
  localparam int RandItems  = 170;
  localparam int HoldCycles = 3000;
  localparam longint CycleLimit = 8000000;

  localparam logic signed [19:0] DeltaMax = 20'sh7FFFF;
  localparam logic signed [19:0] DeltaMin = 20'sh80000;

  typedef mts_pkg::frame_req_t     frame_req_t;
  typedef mts_pkg::corrected_res_t corrected_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mts_stream_if #(.payload_t(frame_req_t))     in_req ();
  mts_stream_if #(.payload_t(corrected_res_t)) out_res ();

  motion_trajectory_smoother i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_req (in_req.sink),
    .out_res(out_res.source)
  );

  always #1 clk = ~clk;

  // Pending requests, expected results and bench control flags.
  frame_req_t     frame_q[$];
  corrected_res_t corrected_q[$];
  int             fail_count = 0;
  bit             quiet = 1'b0;     // no random idling on either side
  bit             hold_go = 1'b0;   // ask the receiver for one long hold-off
  bit             hold_done = 1'b0;
  int             hold_left = 0;
  longint         cycle_count = 0;

  // Predictor state: trajectory ring, saturating sums, sequence position.
  int signed traj_x[Depth];
  int signed traj_y[Depth];
  int signed traj_a[Depth];
  int signed sum_x, sum_y, sum_a;
  int unsigned frame_count, head_slot;

  function automatic int signed clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Round to nearest, ties away from zero, then clamp.
  function automatic int signed round_div(longint num, int unsigned den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + longint'(den / 2)) / longint'(den);
    return clamp32((num < 0) ? -q : q);
  endfunction

  function automatic int unsigned ring_back(int unsigned back);
    return (head_slot + Depth - (back % Depth)) % Depth;
  endfunction

  // Corrected motion of the frame b entries behind the newest of n frames.
  function automatic corrected_res_t smooth_frame(int unsigned b, int unsigned n,
                                                  bit sat_index, bit eor);
    corrected_res_t r;
    int unsigned hi, cnt, s;
    longint sx, sy, sa, px, py, pa;
    sx = 0; sy = 0; sa = 0; px = 0; py = 0; pa = 0;
    hi = b + Radius;
    if (hi > n - 1) hi = n - 1;
    cnt = hi + 1;
    for (int unsigned d = 0; d <= hi; d++) begin
      s = ring_back(d);
      sx += traj_x[s];
      sy += traj_y[s];
      sa += traj_a[s];
    end
    if (b != n - 1) begin
      s = ring_back(b + 1);
      px = traj_x[s];
      py = traj_y[s];
      pa = traj_a[s];
    end
    r.frame_index     = sat_index ? 16'hFFFF : 16'((n - 1 - b) & 16'hFFFF);
    r.corrected_x     = round_div(sx - longint'(cnt) * px, cnt);
    r.corrected_y     = round_div(sy - longint'(cnt) * py, cnt);
    r.corrected_angle = round_div(sa - longint'(cnt) * pa, cnt);
    r.end_of_run      = eor;
    return r;
  endfunction

  // Advance the trajectory by one accepted request and queue its results.
  task automatic track_frame(frame_req_t f);
    bit sat_index;
    int unsigned n, b;
    sat_index = (frame_count >= 65535);
    n = frame_count + 1;
    sum_x = clamp32(longint'(sum_x) + longint'(f.delta_x));
    sum_y = clamp32(longint'(sum_y) + longint'(f.delta_y));
    sum_a = clamp32(longint'(sum_a) + longint'(f.delta_angle));
    traj_x[head_slot] = sum_x;
    traj_y[head_slot] = sum_y;
    traj_a[head_slot] = sum_a;
    if (f.last_frame) begin
      // Flush every pending frame, oldest first.
      b = (n - 1 > Radius) ? Radius : n - 1;
      while (1) begin
        corrected_q.insert(corrected_q.size(), smooth_frame(b, n, sat_index, b == 0));
        if (b == 0) break;
        b--;
      end
      sum_x = 0; sum_y = 0; sum_a = 0;
      frame_count = 0;
      head_slot = 0;
    end else begin
      if (n >= Radius + 1)
        corrected_q.insert(corrected_q.size(), smooth_frame(Radius, n, sat_index, 1'b0));
      head_slot = (head_slot + 1) % Depth;
      frame_count = sat_index ? 65535 : n;
    end
  endtask

  // Driver: offer queued requests, drop valid at random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_req.valid   <= 1'b0;
      in_req.payload <= '0;
    end else begin
      if (in_req.valid && in_req.ready) track_frame(in_req.payload);
      if (!in_req.valid || in_req.ready) begin
        if (frame_q.size() > 0 && (quiet || $urandom_range(99) >= 34)) begin
          in_req.payload <= frame_q.pop_front();
          in_req.valid   <= 1'b1;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, stall ready at random or on a hold.
  always @(posedge clk) begin
    corrected_res_t got, exp_r;
    if (rst) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        got = out_res.payload;
        if (corrected_q.size() == 0) begin
          $error("unexpected result for frame %0d", got.frame_index);
          fail_count++;
        end else begin
          exp_r = corrected_q.pop_front();
          if (got.frame_index !== exp_r.frame_index) begin
            $error("frame_index expected %0d got %0d", exp_r.frame_index, got.frame_index);
            fail_count++;
          end
          if (got.corrected_x !== exp_r.corrected_x) begin
            $error("corrected_x expected %0d got %0d", exp_r.corrected_x, got.corrected_x);
            fail_count++;
          end
          if (got.corrected_y !== exp_r.corrected_y) begin
            $error("corrected_y expected %0d got %0d", exp_r.corrected_y, got.corrected_y);
            fail_count++;
          end
          if (got.corrected_angle !== exp_r.corrected_angle) begin
            $error("corrected_angle expected %0d got %0d", exp_r.corrected_angle,
                   got.corrected_angle);
            fail_count++;
          end
          if (got.end_of_run !== exp_r.end_of_run) begin
            $error("end_of_run expected %0d got %0d", exp_r.end_of_run, got.end_of_run);
            fail_count++;
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_res.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= quiet || ($urandom_range(99) >= 34);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL motion_trajectory_smoother");
      $finish;
    end
  end

  function automatic logic signed [19:0] pick_delta();
    logic signed [19:0] d;
    case ($urandom_range(7))
      0: d = DeltaMax;
      1: d = DeltaMin;
      2: d = '0;
      3, 4: d = 20'($urandom_range(4000)) - 20'sd2000;
      default: d = 20'($urandom);
    endcase
    return d;
  endfunction

  task automatic add_frame(logic signed [19:0] dx, logic signed [19:0] dy,
                           logic signed [19:0] da, bit last);
    frame_req_t f;
    f.delta_x = dx;
    f.delta_y = dy;
    f.delta_angle = da;
    f.last_frame = last;
    frame_q.insert(frame_q.size(), f);
  endtask

  // Hold the sender until every request is taken and every result is back.
  task automatic wait_drained();
    while (frame_q.size() > 0 || in_req.valid || corrected_q.size() > 0 || hold_left > 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned rand_sent, seq_len, seq_no;
    in_req.valid   = 1'b0;
    in_req.payload = '0;
    out_res.ready  = 1'b0;
    sum_x = 0; sum_y = 0; sum_a = 0;
    frame_count = 0; head_slot = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // One-frame sequences at both extremes: corrected equals the trajectory.
    add_frame(DeltaMax, DeltaMin, DeltaMax, 1'b1);
    add_frame(DeltaMin, DeltaMax, DeltaMin, 1'b1);
    // Short sequences, clipped windows.
    add_frame(DeltaMin, DeltaMin, DeltaMin, 1'b0);
    add_frame(DeltaMin, DeltaMin, DeltaMin, 1'b1);
    add_frame(20'sd256, -20'sd256, 20'sd1, 1'b0);
    add_frame(-20'sd1, 20'sd3, -20'sd65536, 1'b0);
    add_frame(DeltaMax, 20'sd0, DeltaMin, 1'b1);
    wait_drained();

    // Random sequences, mostly long enough to complete windows.
    rand_sent = 0;
    seq_no = 0;
    while (rand_sent < RandItems) begin
      if (seq_no == 0) seq_len = 100;
      else if ($urandom_range(3) == 0) seq_len = $urandom_range(1, 12);
      else seq_len = $urandom_range(52, 110);
      if (seq_len > RandItems - rand_sent) seq_len = RandItems - rand_sent;
      quiet = (seq_no == 1);
      for (int unsigned k = 0; k < seq_len; k++)
        add_frame(pick_delta(), pick_delta(), pick_delta(), k == seq_len - 1);
      // Stall the receiver early in the first sequence so the block backs up.
      if (seq_no == 0) begin
        while (frame_q.size() > 40) @(posedge clk);
        hold_go = 1'b1;
      end
      rand_sent += seq_len;
      seq_no++;
      wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS motion_trajectory_smoother");
    end else begin
      $display("FAIL motion_trajectory_smoother");
    end
    $finish;
  end

endmodule
